// ===== hdl/tmph_pkg.sv =====
// Shared constants, types and control structs of the trimmed-mean pH filter.
package tmph_pkg;

    // Field widths
    localparam int SAMPLE_W = 10;
    localparam int MEAN_W   = 18;
    localparam int PH_W     = 17;
    localparam int SLOPE_W  = 14;
    localparam int OFFSET_W = 12;

    // Configuration port
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 3;

    // Arithmetic constants
    localparam int DEF_WINDOW  = 40;
    localparam int TRIM_MIN_W  = 5;   // windows below this take a plain mean
    localparam int Q_SHIFT     = 8;   // Q8 mean
    localparam int SCALE_SHIFT = 18;  // 5 V / 1024 codes / 256 (Q8)

    localparam logic [SLOPE_W-1:0]         SLOPE_RESET  = 14'd3500;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 12'sd0;

    localparam logic signed [PH_W+1:0] PH_MAX = 19'sd65535;
    localparam logic signed [PH_W+1:0] PH_MIN = -19'sd65536;

    // Register indexes (word address bit)
    localparam logic REG_SLOPE  = 1'b0;
    localparam logic REG_OFFSET = 1'b1;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SCAN,
        S_DRAIN,
        S_DLOAD,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic wr_en;
        logic scan_clr;
        logic scan_rd;
        logic div_load;
        logic div_step;
        logic mul_en;
        logic scale_en;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/tmph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tmph_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 40,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tmph_ctrl.sv =====
// Sequencing state machine: write, ring scan, divide, scale, result hand-off.
module tmph_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tmph_pkg::t_dp_sts i_sts,
    output tmph_pkg::t_dp_cmd o_cmd
);

    tmph_pkg::t_state r_state;
    tmph_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmph_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tmph_pkg::S_IDLE: begin
                if (i_valid) n_state = tmph_pkg::S_WRITE;
            end
            tmph_pkg::S_WRITE: n_state = tmph_pkg::S_SCAN;
            tmph_pkg::S_SCAN: begin
                if (i_sts.scan_last) n_state = tmph_pkg::S_DRAIN;
            end
            tmph_pkg::S_DRAIN: n_state = tmph_pkg::S_DLOAD;
            tmph_pkg::S_DLOAD: n_state = tmph_pkg::S_DIV;
            tmph_pkg::S_DIV:   n_state = tmph_pkg::S_MUL;
            tmph_pkg::S_MUL:   n_state = tmph_pkg::S_SCALE;
            tmph_pkg::S_SCALE: n_state = tmph_pkg::S_OUT;
            tmph_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = tmph_pkg::S_IDLE;
            end
            default: n_state = tmph_pkg::S_IDLE;
        endcase
    end

    // Command decode
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            tmph_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            tmph_pkg::S_WRITE: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            tmph_pkg::S_SCAN:  o_cmd.scan_rd  = 1'b1;
            tmph_pkg::S_DRAIN: o_cmd          = '0;
            tmph_pkg::S_DLOAD: o_cmd.div_load = 1'b1;
            tmph_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            tmph_pkg::S_MUL:   o_cmd.mul_en   = 1'b1;
            tmph_pkg::S_SCALE: o_cmd.scale_en = 1'b1;
            tmph_pkg::S_OUT:   o_cmd.out_load = i_sts.out_free;
            default:           o_cmd          = '0;
        endcase
    end

endmodule

// ===== hdl/tmph_dp.sv =====
// Datapath: sample ring, sum/min/max scan, reciprocal divide, pH scaling, output beat.
module tmph_dp #(
    parameter int WINDOW = tmph_pkg::DEF_WINDOW
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  tmph_pkg::t_dp_cmd                         i_cmd,
    output tmph_pkg::t_dp_sts                         o_sts,
    input  logic [tmph_pkg::SAMPLE_W-1:0]             i_sample,
    input  logic [tmph_pkg::SLOPE_W-1:0]              i_slope,
    input  logic signed [tmph_pkg::OFFSET_W-1:0]      i_offset,
    input  logic                                      i_ready,
    output logic                                      o_valid,
    output logic [tmph_pkg::MEAN_W-1:0]               o_mean_q8,
    output logic signed [tmph_pkg::PH_W-1:0]          o_ph_milli
);

    localparam int SW      = tmph_pkg::SAMPLE_W;
    localparam int AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = $clog2(WINDOW * ((1 << SW) - 1) + 1);
    localparam int NUM_W   = SUM_W + tmph_pkg::Q_SHIFT;
    localparam int DIVISOR = (WINDOW < tmph_pkg::TRIM_MIN_W) ? WINDOW : WINDOW - 2;
    localparam int DVW     = $clog2(DIVISOR + 1);
    // Reciprocal of the divisor, exact floor quotient for any dividend below 2^NUM_W
    localparam int RCP_S   = NUM_W + DVW;
    localparam int RCP_W   = NUM_W + 2;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
    localparam int QPROD_W = NUM_W + RCP_W;
    localparam int QUOT_W  = QPROD_W - RCP_S;
    localparam int PROD_W  = tmph_pkg::MEAN_W + tmph_pkg::SLOPE_W;
    localparam int P5_W    = PROD_W + 3;

    // Sample capture and ring write pointer
    logic [SW-1:0]     r_sample;
    logic [AW-1:0]     r_wpos;
    logic [WINDOW-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_vld  <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[r_wpos] <= 1'b1;
            if (r_wpos == AW'(WINDOW - 1)) begin
                r_wpos <= '0;
            end else begin
                r_wpos <= r_wpos + 1'b1;
            end
        end
    end

    // Ring scan: read address and pending-data flag
    logic [AW-1:0] r_raddr;
    logic          r_rpend;
    logic          r_rvld;
    logic [SW-1:0] ram_rdata;
    logic [SW-1:0] rd_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpend <= 1'b0;
        end else begin
            r_rpend <= i_cmd.scan_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_vld[r_raddr];
        if (i_cmd.scan_clr) begin
            r_raddr <= '0;
        end else if (i_cmd.scan_rd) begin
            r_raddr <= r_raddr + 1'b1;
        end
    end

    tmph_ram #(
        .WIDTH  (SW),
        .DEPTH  (WINDOW),
        .ADDR_W (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_wpos),
        .i_wdata (r_sample),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    // Entries never written read as zero
    assign rd_val = r_rvld ? ram_rdata : '0;

    // Sum, min and max accumulation
    logic [SUM_W-1:0] r_sum;
    logic [SW-1:0]    r_lo;
    logic [SW-1:0]    r_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_sum <= '0;
            r_lo  <= '1;
            r_hi  <= '0;
        end else if (r_rpend) begin
            r_sum <= r_sum + SUM_W'(rd_val);
            if (rd_val < r_lo) r_lo <= rd_val;
            if (rd_val > r_hi) r_hi <= rd_val;
        end
    end

    // Dividend: trimmed sum in Q8, or plain sum for small windows
    logic [SUM_W-1:0] trim;
    logic [NUM_W-1:0] dvd_init;

    assign trim = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);

    always_comb begin
        if (WINDOW < tmph_pkg::TRIM_MIN_W) begin
            dvd_init = NUM_W'(r_sum);
        end else begin
            dvd_init = NUM_W'({trim, {tmph_pkg::Q_SHIFT{1'b0}}});
        end
    end

    // Divide by the constant divisor: multiply by its reciprocal, keep the high bits
    logic [NUM_W-1:0]   r_dvd;
    logic [QUOT_W-1:0]  r_quot;
    logic [QPROD_W-1:0] qprod;

    assign qprod = QPROD_W'(r_dvd) * QPROD_W'(RCP_M);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= dvd_init;
        end
        if (i_cmd.div_step) begin
            r_quot <= qprod[RCP_S +: QUOT_W];
        end
    end

    // Mean in Q8 from the quotient
    logic [tmph_pkg::MEAN_W-1:0] mean_q;

    always_comb begin
        if (WINDOW < tmph_pkg::TRIM_MIN_W) begin
            mean_q = {r_quot[SW-1:0], {tmph_pkg::Q_SHIFT{1'b0}}};
        end else begin
            mean_q = r_quot[tmph_pkg::MEAN_W-1:0];
        end
    end

    // Slope multiply
    logic [tmph_pkg::MEAN_W-1:0] r_mean;
    logic [PROD_W-1:0]           r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_mean <= mean_q;
            r_prod <= PROD_W'(mean_q) * PROD_W'(i_slope);
        end
    end

    // Times five, drop Q bits, add offset, saturate
    logic [P5_W-1:0]                     p5;
    logic [tmph_pkg::PH_W-1:0]           scaled;
    logic signed [tmph_pkg::PH_W+1:0]    ph_sum;
    logic signed [tmph_pkg::PH_W-1:0]    ph_sat;
    logic signed [tmph_pkg::PH_W-1:0]    r_ph;

    assign p5     = {1'b0, r_prod, 2'b00} + P5_W'(r_prod);
    assign scaled = p5[tmph_pkg::SCALE_SHIFT +: tmph_pkg::PH_W];
    assign ph_sum = $signed({2'b00, scaled}) + (tmph_pkg::PH_W + 2)'(i_offset);

    always_comb begin
        if (ph_sum > tmph_pkg::PH_MAX) begin
            ph_sat = tmph_pkg::PH_MAX[tmph_pkg::PH_W-1:0];
        end else if (ph_sum < tmph_pkg::PH_MIN) begin
            ph_sat = tmph_pkg::PH_MIN[tmph_pkg::PH_W-1:0];
        end else begin
            ph_sat = ph_sum[tmph_pkg::PH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale_en) begin
            r_ph <= ph_sat;
        end
    end

    // Output register: holds the beat until the sink takes it
    logic                        r_ovalid;
    logic [tmph_pkg::MEAN_W-1:0] r_omean;
    logic signed [tmph_pkg::PH_W-1:0] r_oph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_omean <= r_mean;
            r_oph   <= r_ph;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_mean_q8  = r_omean;
    assign o_ph_milli = r_oph;

    // Status back to the controller
    assign o_sts.scan_last = (r_raddr == AW'(WINDOW - 1));
    assign o_sts.out_free  = !r_ovalid || i_ready;

endmodule

// ===== hdl/trimmed_mean_ph_filter_top.sv =====
// Samples are taken one at a time: a new sample is accepted only in the idle state, after the
// previous result has entered the output register; o_ready rises in the same cycle as o_valid.
// Per-item time is set by the ring scan (one RAM read per entry); divide is one multiply.
// A finished beat waits in the output register while the next sample is taken.
// Reset (synchronous, active low): ring reads as all zero via per-entry valid bits,
// write pointer zero, slope 3500, offset 0; no clearing pass is needed.
module trimmed_mean_ph_filter_top #(
    parameter int WINDOW = tmph_pkg::DEF_WINDOW
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample channel
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [tmph_pkg::SAMPLE_W-1:0]         i_sample,
    // Result channel
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [tmph_pkg::MEAN_W-1:0]           o_mean_q8,
    output logic signed [tmph_pkg::PH_W-1:0]      o_ph_milli,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tmph_pkg::PADDR_W-1:0]          paddr,
    input  logic [tmph_pkg::DATA_W-1:0]           pwdata,
    output logic [tmph_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);

    // Configuration registers
    logic [tmph_pkg::SLOPE_W-1:0]         r_slope;
    logic signed [tmph_pkg::OFFSET_W-1:0] r_offset;
    logic                                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope  <= tmph_pkg::SLOPE_RESET;
            r_offset <= tmph_pkg::OFFSET_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                tmph_pkg::REG_SLOPE:  r_slope  <= pwdata[tmph_pkg::SLOPE_W-1:0];
                tmph_pkg::REG_OFFSET: r_offset <= pwdata[tmph_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            tmph_pkg::REG_SLOPE:  prdata = tmph_pkg::DATA_W'(r_slope);
            tmph_pkg::REG_OFFSET: prdata = tmph_pkg::DATA_W'($unsigned(r_offset));
            default:              prdata = '0;
        endcase
    end

    // Controller and datapath
    tmph_pkg::t_dp_cmd cmd;
    tmph_pkg::t_dp_sts sts;

    tmph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tmph_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_sample   (i_sample),
        .i_slope    (r_slope),
        .i_offset   (r_offset),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_mean_q8  (o_mean_q8),
        .o_ph_milli (o_ph_milli)
    );

endmodule

// ===== dv/tmph_checker.sv =====
// Scoreboard for the trimmed-mean pH filter: tracks ring and registers, predicts, compares beats.
module tmph_checker #(
    parameter int WINDOW = tmph_pkg::DEF_WINDOW
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Sample channel
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic [tmph_pkg::SAMPLE_W-1:0]         i_sample,
    // Result channel
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [tmph_pkg::MEAN_W-1:0]           i_mean_q8,
    input  logic signed [tmph_pkg::PH_W-1:0]      i_ph_milli,
    // Configuration port
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [tmph_pkg::PADDR_W-1:0]          i_paddr,
    input  logic [tmph_pkg::DATA_W-1:0]           i_pwdata,
    input  logic                                  i_pready,
    // Status to the testbench top
    output int                                    o_error_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tmph_pkg::*;

    localparam int SHOWN_MAX = 10;

    typedef struct packed {
        logic [MEAN_W-1:0]      mean_q8;
        logic signed [PH_W-1:0] ph_milli;
    } t_reading;

    // Shadow of the block's state and registers
    logic [SAMPLE_W-1:0]        ring_copy [WINDOW];
    int unsigned                ring_wr;
    logic [SLOPE_W-1:0]         slope_milli;
    logic signed [OFFSET_W-1:0] offset_milli;

    t_reading readings_due [$];
    t_reading oldest;

    // Mean over the shadow ring, trimmed unless below TRIM_MIN_W, scaled to milli-pH with saturation
    function automatic t_reading ring_reading();
        int unsigned     total;
        int unsigned     lo;
        int unsigned     hi;
        logic [31:0]     mean;
        longint unsigned wide_mean;
        longint unsigned scaled;
        longint          ph_full;
        t_reading        r;
        total = 0;
        lo    = (1 << SAMPLE_W) - 1;
        hi    = 0;
        for (int i = 0; i < WINDOW; i++) begin
            total += ring_copy[i];
            if (ring_copy[i] < lo) lo = ring_copy[i];
            if (ring_copy[i] > hi) hi = ring_copy[i];
        end
        if (WINDOW < TRIM_MIN_W) begin
            mean = (total / WINDOW) << Q_SHIFT;
        end else begin
            mean = ((total - lo - hi) << Q_SHIFT) / (WINDOW - 2);
        end
        wide_mean = mean;
        scaled    = (wide_mean * 5 * slope_milli) >> SCALE_SHIFT;
        ph_full   = longint'(scaled) + offset_milli;
        if (ph_full > PH_MAX) ph_full = PH_MAX;
        if (ph_full < PH_MIN) ph_full = PH_MIN;
        r.mean_q8  = mean[MEAN_W-1:0];
        r.ph_milli = ph_full[PH_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input longint wanted, input longint seen);
        if (o_error_count < SHOWN_MAX) begin
            $display("%0t ns: %s mismatch, expected %0d got %0d", $time, field, wanted, seen);
        end
        o_error_count++;
    endtask

    // Everything is sampled at the rising edge; the testbench drives on the falling edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) ring_copy[i] = '0;
            ring_wr      = 0;
            slope_milli  = SLOPE_RESET;
            offset_milli = OFFSET_RESET;
            readings_due.delete();
        end else begin
            // Register write on the access phase
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_SLOPE:  slope_milli  = i_pwdata[SLOPE_W-1:0];
                    REG_OFFSET: offset_milli = i_pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            // Sample beat: update ring, queue the expected reading
            if (i_in_valid && i_in_ready) begin
                ring_copy[ring_wr] = i_sample;
                ring_wr = (ring_wr + 1 >= WINDOW) ? 0 : ring_wr + 1;
                readings_due.push_back(ring_reading());
            end
            // Result beat: compare against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    if (o_error_count < SHOWN_MAX) begin
                        $display("%0t ns: result beat with nothing expected, %s %0d %s %0d",
                                 $time, "mean_q8", i_mean_q8, "ph_milli", i_ph_milli);
                    end
                    o_error_count++;
                end else begin
                    oldest = readings_due.pop_front();
                    if (i_mean_q8 !== oldest.mean_q8)
                        flag_mismatch("mean_q8", oldest.mean_q8, i_mean_q8);
                    if (i_ph_milli !== oldest.ph_milli)
                        flag_mismatch("ph_milli", oldest.ph_milli, i_ph_milli);
                end
            end
        end
        o_pending = readings_due.size();
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the trimmed-mean pH filter: clock, reset, stimulus, back-pressure, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmph_pkg::*;

    localparam int WINDOW         = DEF_WINDOW;
    localparam int LATENCY        = WINDOW + 7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 90;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

    // Sample mixes for the random phases
    typedef enum int {
        MIX_UNIFORM,
        MIX_HIGH,
        MIX_LOW,
        MIX_TIES,
        MIX_DRIFT
    } t_mix;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic [SAMPLE_W-1:0]          i_sample;
    logic                         o_valid;
    logic                         i_ready;
    logic [MEAN_W-1:0]            o_mean_q8;
    logic signed [PH_W-1:0]       o_ph_milli;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [PADDR_W-1:0]           paddr;
    logic [DATA_W-1:0]            pwdata;
    logic [DATA_W-1:0]            prdata;
    logic                         pready;

    int error_count;
    int readings_pending;
    int stall_cycles;
    bit burst_mode;
    logic [SAMPLE_W-1:0] last_sample;

    trimmed_mean_ph_filter_top #(.WINDOW(WINDOW)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_mean_q8  (o_mean_q8),
        .o_ph_milli (o_ph_milli),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    tmph_checker #(.WINDOW(WINDOW)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_sample      (i_sample),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_mean_q8     (o_mean_q8),
        .i_ph_milli    (o_ph_milli),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_error_count (error_count),
        .o_pending     (readings_pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap before a sample beat: mostly none, some short, a few long
    function automatic int sample_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_mix mix);
        int v;
        case (mix)
            MIX_HIGH:  v = $urandom_range(880, SAMPLE_MAX);
            MIX_LOW:   v = $urandom_range(0, 40);
            MIX_TIES: begin
                case ($urandom_range(0, 3))
                    0:       v = 0;
                    1:       v = SAMPLE_MAX;
                    default: v = 512;
                endcase
            end
            MIX_DRIFT: begin
                v = int'(last_sample) + $urandom_range(0, 64) - 32;
                if (v < 0) v = 0;
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            end
            default:   v = $urandom_range(0, SAMPLE_MAX);
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    // One sample beat; valid stays up across back-to-back beats
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = sample_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_sample <= value;
        last_sample = value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected reading has come back
    task automatic drain_readings();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (readings_pending != 0);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_filter_regs(input logic [SLOPE_W-1:0] slope,
                                   input logic signed [OFFSET_W-1:0] offset);
        reg_write({REG_SLOPE, 2'b00}, DATA_W'(slope));
        reg_write({REG_OFFSET, 2'b00}, {{(DATA_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});
    endtask

    // Result side back-pressure: runs of ready and stall, some long
    initial begin
        int run;
        int pick;
        logic level;
        i_ready = 1'b0;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                level = 1'b1;
                run   = $urandom_range(1, 8);
            end else if (pick < 65) begin
                level = 1'b1;
                run   = $urandom_range(100, 300);
            end else if (pick < 95) begin
                level = 1'b0;
                run   = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                run   = $urandom_range(20, 60);
            end
            repeat (run) begin
                @(negedge i_clk);
                i_ready <= level;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL trimmed_mean_ph_filter_top");
                $finish;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [SAMPLE_W-1:0]        directed [20];
        logic [SLOPE_W-1:0]         slope;
        logic signed [OFFSET_W-1:0] offset;
        t_mix                       mix;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        burst_mode  = 1'b0;
        last_sample = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, alternating bit patterns, ties against a zero ring
        directed = '{0, SAMPLE_MAX, 0, SAMPLE_MAX, 1, SAMPLE_MAX - 1, 512, 511,
                     10'h155, 10'h2AA, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0,
                     10'h155, 10'h2AA, 1, 1, SAMPLE_MAX};
        foreach (directed[i]) send_sample(directed[i]);

        // Random phases, each with its own register setting and sample mix
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_readings();
            repeat (8) @(negedge i_clk);
            case (ph)
                0: begin
                    slope  = '1;                  // full 14-bit slope, drives saturation
                    offset = 12'sd2047;
                    mix    = MIX_HIGH;
                end
                1: begin
                    slope  = '0;
                    offset = 12'sh800;            // most negative offset
                    mix    = MIX_UNIFORM;
                end
                2: begin
                    slope  = 14'd10000;
                    offset = -12'sd2000;
                    mix    = MIX_TIES;
                end
                3: begin
                    slope  = SLOPE_RESET;
                    offset = OFFSET_RESET;
                    mix    = MIX_LOW;
                end
                default: begin
                    slope  = SLOPE_W'($urandom_range(0, (1 << SLOPE_W) - 1));
                    offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
                    mix    = t_mix'($urandom_range(MIX_UNIFORM, MIX_DRIFT));
                end
            endcase
            set_filter_regs(slope, offset);
            burst_mode = (ph % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(mix));
        end

        drain_readings();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS trimmed_mean_ph_filter_top");
        end else begin
            $display("FAIL trimmed_mean_ph_filter_top");
        end
        $finish;
    end

endmodule
